### src/modbus_tcp_master_framer_assert.svh
// assertion macros for the modbus tcp master framer
// used by the top level; needs clk and arst_n in the including scope
`ifndef MODBUS_TCP_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_TCP_MASTER_FRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MTF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define MTF_ASSERT_IMPLY(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);
`else
`define MTF_ASSERT_ALWAYS(lbl, expr, msg)
`define MTF_ASSERT_IMPLY(lbl, cond, expr, msg)
`endif
`endif

### src/mtf_pkg.sv
// types and codes shared by the modbus tcp master framer modules
// no dependencies
package mtf_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_WORD  = 2'd1;
	localparam logic [1:0] ACT_RX    = 2'd2;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_COIL   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EXC   = 2'd1;
	localparam logic [1:0] ST_ZLEN  = 2'd2;
	localparam logic [1:0] ST_SHORT = 2'd3;

	localparam logic [1:0] RK_WRITE = 2'd0;
	localparam logic [1:0] RK_REG   = 2'd1;
	localparam logic [1:0] RK_BIT   = 2'd2;

	localparam logic [7:0]  FC_READ_COILS  = 8'h01;
	localparam logic [7:0]  FC_READ_DISC   = 8'h02;
	localparam logic [7:0]  FC_READ_HOLD   = 8'h03;
	localparam logic [7:0]  FC_READ_INPUT  = 8'h04;
	localparam logic [7:0]  FC_WRITE_COIL  = 8'h05;
	localparam logic [7:0]  FC_WRITE_REG   = 8'h06;
	localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
	localparam logic [15:0] COIL_ON        = 16'hFF00;
	localparam logic [15:0] COIL_OFF       = 16'h0000;

	typedef enum logic [1:0] {
		JOB_START,
		JOB_WORD,
		JOB_RX
	} job_kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  fcode;
		logic [15:0] start_address;
		logic [10:0] quantity;
		logic [15:0] word_value;
		logic [7:0]  rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [15:0] data_word;
		logic [1:0]  status;
		logic [7:0]  exception_code;
		logic        last;
	} res_t;

	// one queued job: a request header, a payload word or a parsed response byte
	typedef struct packed {
		job_kind_t   jkind;
		logic [3:0]  n_res;
		logic [3:0]  n_data;
		logic [15:0] tid;
		logic [8:0]  len;
		logic [7:0]  unit;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] word;
		logic [7:0]  aux;
		logic        reg_data;
		logic [1:0]  st;
		logic [7:0]  exc;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

### src/mtf_front.sv
// front end: takes requests, tracks transaction and response parse state,
// and turns each request into at most one job; depends on mtf_pkg
module mtf_front #(
	parameter int MAX_WRITE_WORDS = 123
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	input  logic           take,
	input  mtf_pkg::cmd_t  cmd,
	output logic           job_push,
	output mtf_pkg::job_t  job
);

	localparam int QW = $clog2(MAX_WRITE_WORDS + 1);
	localparam logic [10:0] MAXW = 11'(MAX_WRITE_WORDS);

	logic [7:0]  unit_q;
	logic [15:0] tid_q, tid_n;
	logic [15:0] idx_q, idx_n;
	logic [15:0] rlen_q, rlen_n;
	logic [7:0]  rfunc_q, rfunc_n;
	logic [7:0]  rbc_q, rbc_n;
	logic [7:0]  held_q, held_n;
	logic [10:0] bits_q, bits_n;
	logic [1:0]  rk_q, rk_n;

	logic [7:0]  b;
	logic [7:0]  fn, bc;
	logic [15:0] d, len_dec;
	logic        in_data;
	logic [3:0]  nb;
	logic [QW-1:0] q;
	logic [8:0]  q2;

	always_comb begin
		b       = cmd.rx_byte;
		fn      = (idx_q == 16'd7) ? b : rfunc_q;
		bc      = (idx_q == 16'd8) ? b : rbc_q;
		d       = idx_q - 16'd9;
		in_data = (idx_q >= 16'd9) && !fn[7] && (d < {8'd0, bc});
		len_dec = rlen_q - 16'd1;
		nb      = (bits_q >= 11'd8) ? 4'd8 : bits_q[3:0];
		q       = (cmd.quantity > MAXW) ? QW'(MAX_WRITE_WORDS) : QW'(cmd.quantity);
		q2      = 9'({q, 1'b0});

		tid_n   = tid_q;
		idx_n   = idx_q;
		rlen_n  = rlen_q;
		rfunc_n = rfunc_q;
		rbc_n   = rbc_q;
		held_n  = held_q;
		bits_n  = bits_q;
		rk_n    = rk_q;
		job_push = 1'b0;
		job      = '0;

		if (take) begin
			case (cmd.action)
				mtf_pkg::ACT_START: begin
					tid_n = tid_q + 16'd1;
					if (cmd.fcode == mtf_pkg::FC_READ_HOLD ||
					    cmd.fcode == mtf_pkg::FC_READ_INPUT) begin
						rk_n = mtf_pkg::RK_REG;
					end else if (cmd.fcode == mtf_pkg::FC_READ_COILS ||
					             cmd.fcode == mtf_pkg::FC_READ_DISC) begin
						rk_n = mtf_pkg::RK_BIT;
					end else begin
						rk_n = mtf_pkg::RK_WRITE;
					end
					bits_n  = (rk_n != mtf_pkg::RK_WRITE) ? cmd.quantity : 11'd0;
					idx_n   = '0;
					rlen_n  = '0;
					rfunc_n = '0;
					rbc_n   = '0;
					job_push  = 1'b1;
					job.jkind = mtf_pkg::JOB_START;
					job.tid   = tid_n;
					job.unit  = unit_q;
					job.func  = cmd.fcode;
					job.addr  = cmd.start_address;
					job.n_res = 4'd12;
					job.len   = 9'd6;
					if (cmd.fcode == mtf_pkg::FC_WRITE_MULTI) begin
						job.n_res = 4'd13;
						job.len   = 9'd7 + q2;
						job.word  = 16'(q);
						job.aux   = q2[7:0];
					end else if (cmd.fcode == mtf_pkg::FC_WRITE_COIL) begin
						job.word = (cmd.word_value != 16'd0) ? mtf_pkg::COIL_ON
						                                     : mtf_pkg::COIL_OFF;
					end else if (cmd.fcode == mtf_pkg::FC_WRITE_REG) begin
						job.word = cmd.word_value;
					end else begin
						job.word = {5'd0, cmd.quantity};
					end
				end
				mtf_pkg::ACT_WORD: begin
					job_push  = 1'b1;
					job.jkind = mtf_pkg::JOB_WORD;
					job.word  = cmd.word_value;
					job.n_res = 4'd2;
				end
				mtf_pkg::ACT_RX: begin
					job.jkind = mtf_pkg::JOB_RX;
					if (idx_q < 16'd4) begin
						idx_n = idx_q + 16'd1;
					end else if (idx_q == 16'd4) begin
						held_n = b;
						idx_n  = 16'd5;
					end else if (idx_q == 16'd5) begin
						rlen_n = {held_q, b};
						if (rlen_n == 16'd0) begin
							job_push  = 1'b1;
							job.n_res = 4'd1;
							job.st    = mtf_pkg::ST_ZLEN;
							idx_n   = '0;
							rfunc_n = '0;
							rbc_n   = '0;
							bits_n  = '0;
						end else begin
							idx_n = 16'd6;
						end
					end else begin
						rfunc_n = fn;
						rbc_n   = bc;
						if (in_data) begin
							if (rk_q == mtf_pkg::RK_REG) begin
								if (!d[0]) begin
									held_n = b;
								end else if (bits_q != 11'd0) begin
									job.n_data   = 4'd1;
									job.reg_data = 1'b1;
									job.word     = {held_q, b};
									bits_n       = bits_q - 11'd1;
								end
							end else if (rk_q == mtf_pkg::RK_BIT) begin
								job.n_data = nb;
								job.aux    = b;
								bits_n     = bits_q - {7'd0, nb};
							end
						end
						job.n_res = job.n_data;
						if (len_dec == 16'd0) begin
							// frame complete: close with a status result
							job.n_res = job.n_data + 4'd1;
							if (fn[7]) begin
								job.st  = mtf_pkg::ST_EXC;
								job.exc = (idx_q >= 16'd8) ? bc : 8'd0;
							end else if (rk_q != mtf_pkg::RK_WRITE && idx_q < 16'd8) begin
								job.st = mtf_pkg::ST_SHORT;
							end else begin
								job.st = mtf_pkg::ST_OK;
							end
							idx_n   = '0;
							rlen_n  = '0;
							rfunc_n = '0;
							rbc_n   = '0;
							bits_n  = '0;
						end else begin
							rlen_n = len_dec;
							idx_n  = (idx_q == 16'hFFFF) ? idx_q : idx_q + 16'd1;
						end
						job_push = (job.n_res != 4'd0);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q  <= '0;
			tid_q   <= '0;
			idx_q   <= '0;
			rlen_q  <= '0;
			rfunc_q <= '0;
			rbc_q   <= '0;
			held_q  <= '0;
			bits_q  <= '0;
			rk_q    <= mtf_pkg::RK_WRITE;
		end else begin
			if (cfg_we) begin
				unit_q <= cfg_wdata;
			end
			tid_q   <= tid_n;
			idx_q   <= idx_n;
			rlen_q  <= rlen_n;
			rfunc_q <= rfunc_n;
			rbc_q   <= rbc_n;
			held_q  <= held_n;
			bits_q  <= bits_n;
			rk_q    <= rk_n;
		end
	end

endmodule

### src/mtf_queue.sv
// short job queue between front and back end
// depends on mtf_pkg
module mtf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mtf_pkg::job_t   push_job,
	input  logic            pop,
	output mtf_pkg::job_t   head,
	output mtf_pkg::qstat_t stat
);

	mtf_pkg::job_t                   mem_q [mtf_pkg::QDEPTH];
	logic [mtf_pkg::QPTR_W-1:0]      wr_q, rd_q;
	logic [mtf_pkg::QCNT_W-1:0]      cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == mtf_pkg::QCNT_W'(mtf_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == mtf_pkg::QPTR_W'(mtf_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == mtf_pkg::QPTR_W'(mtf_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/mtf_back.sv
// back end: walks the head job one result per cycle, while the output is not stalled, into the output register
// depends on mtf_pkg
module mtf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mtf_pkg::job_t   head,
	input  mtf_pkg::qstat_t qstat,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output mtf_pkg::res_t   res
);

	logic [3:0]    step_q;
	logic          vld_q;
	mtf_pkg::res_t res_q;
	mtf_pkg::res_t nxt;
	logic          advance;
	logic          is_last;

	assign advance   = !vld_q || !res_stall;
	assign is_last   = (step_q == head.n_res - 4'd1);
	assign pop       = advance && !qstat.empty && is_last;
	assign res_valid = vld_q;
	assign res       = res_q;

	always_comb begin
		nxt      = '0;
		nxt.last = is_last;
		case (head.jkind)
			mtf_pkg::JOB_START: begin
				nxt.kind = mtf_pkg::KIND_TX;
				case (step_q)
					4'd0:    nxt.tx_byte = head.tid[15:8];
					4'd1:    nxt.tx_byte = head.tid[7:0];
					4'd4:    nxt.tx_byte = {7'd0, head.len[8]};
					4'd5:    nxt.tx_byte = head.len[7:0];
					4'd6:    nxt.tx_byte = head.unit;
					4'd7:    nxt.tx_byte = head.func;
					4'd8:    nxt.tx_byte = head.addr[15:8];
					4'd9:    nxt.tx_byte = head.addr[7:0];
					4'd10:   nxt.tx_byte = head.word[15:8];
					4'd11:   nxt.tx_byte = head.word[7:0];
					4'd12:   nxt.tx_byte = head.aux;
					default: nxt.tx_byte = 8'd0;
				endcase
			end
			mtf_pkg::JOB_WORD: begin
				nxt.kind    = mtf_pkg::KIND_TX;
				nxt.tx_byte = step_q[0] ? head.word[7:0] : head.word[15:8];
			end
			mtf_pkg::JOB_RX: begin
				if (step_q < head.n_data) begin
					if (head.reg_data) begin
						nxt.kind      = mtf_pkg::KIND_REG;
						nxt.data_word = head.word;
					end else begin
						// coil bits go out lsb first
						nxt.kind      = mtf_pkg::KIND_COIL;
						nxt.data_word = {15'd0, head.aux[step_q[2:0]]};
					end
				end else begin
					nxt.kind           = mtf_pkg::KIND_STATUS;
					nxt.status         = head.st;
					nxt.exception_code = head.exc;
				end
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && !qstat.empty) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			step_q <= '0;
		end else if (advance) begin
			vld_q <= !qstat.empty;
			if (!qstat.empty) begin
				step_q <= is_last ? 4'd0 : step_q + 4'd1;
			end
		end
	end

endmodule

### src/modbus_tcp_master_framer.sv
// modbus tcp master framer: request builder and response parser.
// results: a start request gives 12 results (13 for function 0x10), a payload word 2,
// a response byte up to 9 (register word or up to 8 coil bits plus status), one result
// per cycle while not stalled; jobs pass through the job queue, then the output register.
// reset clears transaction id, parse state, job queue and output valid; unit address is 0.
`include "modbus_tcp_master_framer_assert.svh"
module modbus_tcp_master_framer #(
	parameter int MAX_WRITE_WORDS = 123
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  mtf_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output mtf_pkg::res_t res
);

	logic            take;
	logic            job_push;
	mtf_pkg::job_t   job;
	mtf_pkg::job_t   head;
	mtf_pkg::qstat_t qstat;
	logic            pop;
	logic            res_is_status;
	logic            res_is_tx;

	assign cmd_stall = qstat.full;
	assign take      = cmd_valid && !qstat.full;

	assign res_is_status = (res.kind == mtf_pkg::KIND_STATUS);
	assign res_is_tx     = (res.kind == mtf_pkg::KIND_TX);

	mtf_front #(
		.MAX_WRITE_WORDS(MAX_WRITE_WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.take     (take),
		.cmd      (cmd),
		.job_push (job_push),
		.job      (job)
	);

	mtf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(job),
		.pop     (pop),
		.head    (head),
		.stat    (qstat)
	);

	mtf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	`MTF_ASSERT_IMPLY(a_pop_nonempty, pop, !qstat.empty, "pop from empty job queue")
	`MTF_ASSERT_IMPLY(a_push_room, job_push, !qstat.full, "push into full job queue")
	`MTF_ASSERT_IMPLY(a_status_last, res_valid && res_is_status, res.last, "status not last")
	`MTF_ASSERT_IMPLY(a_tx_only, res_valid && !res_is_tx, res.tx_byte == 8'd0, "stray tx byte")

endmodule

### tb/sv/mtf_checker.sv
`timescale 1ns / 1ps
// result checker for the modbus tcp master framer: mirrors the request builder and
// the response parser, then compares every accepted result; depends on mtf_pkg
module mtf_checker #(
	parameter int MAX_WRITE_WORDS = 123
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  mtf_pkg::cmd_t cmd,
	input  logic          res_valid,
	input  logic          res_stall,
	input  mtf_pkg::res_t res,
	output int            n_due,
	output int            n_bad
);
	import mtf_pkg::*;

	logic [7:0]  unit_id;
	logic [15:0] tid;
	logic [15:0] rx_pos;
	logic [15:0] rx_left;
	logic [7:0]  rx_fc;
	logic [7:0]  rx_count;
	logic [7:0]  hi_byte;
	logic [15:0] bits_left;
	logic [1:0]  req_kind;

	res_t due_res[$];
	res_t step_res[$];
	int   bad_count = 0;

	function automatic void emit(logic [1:0] k, logic [7:0] tx, logic [15:0] dw,
		logic [1:0] st, logic [7:0] exc);
		res_t r;
		r.kind = k;
		r.tx_byte = tx;
		r.data_word = dw;
		r.status = st;
		r.exception_code = exc;
		r.last = 1'b0;
		step_res.insert(step_res.size(), r);
	endfunction

	function automatic void emit_tx(logic [7:0] b);
		emit(KIND_TX, b, 16'h0000, ST_OK, 8'h00);
	endfunction

	function automatic void drop_frame();
		rx_pos = 16'd0;
		rx_left = 16'd0;
		rx_fc = 8'h00;
		rx_count = 8'h00;
	endfunction

	function automatic void close_frame(logic [1:0] st, logic [7:0] exc);
		emit(KIND_STATUS, 8'h00, 16'h0000, st, exc);
		drop_frame();
		bits_left = 16'd0;
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		logic [15:0] pos;
		logic [15:0] d;
		logic [1:0]  st;
		logic [7:0]  exc;
		pos = rx_pos;
		st = ST_OK;
		exc = 8'h00;
		if (pos < 16'd4) begin
			rx_pos = pos + 16'd1;
			return;
		end
		if (pos == 16'd4) begin
			hi_byte = b;
			rx_pos = 16'd5;
			return;
		end
		if (pos == 16'd5) begin
			rx_left = {hi_byte, b};
			if (rx_left == 16'd0)
				close_frame(ST_ZLEN, 8'h00);
			else
				rx_pos = 16'd6;
			return;
		end
		if (pos == 16'd7)
			rx_fc = b;
		if (pos == 16'd8)
			rx_count = b;
		d = pos - 16'd9;
		// data bytes count only inside the byte count and only for a normal reply
		if (pos >= 16'd9 && !rx_fc[7] && d < {8'h00, rx_count}) begin
			if (req_kind == RK_REG) begin
				if (!d[0]) begin
					hi_byte = b;
				end else if (bits_left != 16'd0) begin
					emit(KIND_REG, 8'h00, {hi_byte, b}, ST_OK, 8'h00);
					bits_left = bits_left - 16'd1;
				end
			end else if (req_kind == RK_BIT) begin
				for (int k = 0; k < 8; k++) begin
					if (bits_left != 16'd0) begin
						emit(KIND_COIL, 8'h00, {15'd0, b[k]}, ST_OK, 8'h00);
						bits_left = bits_left - 16'd1;
					end
				end
			end
		end
		rx_left = rx_left - 16'd1;
		if (rx_left == 16'd0) begin
			if (rx_fc[7]) begin
				st = ST_EXC;
				exc = (pos >= 16'd8) ? rx_count : 8'h00;
			end else if (req_kind != RK_WRITE && pos < 16'd8) begin
				st = ST_SHORT;
			end
			close_frame(st, exc);
		end else if (pos != 16'hFFFF) begin
			rx_pos = pos + 16'd1;
		end
	endfunction

	function automatic void apply_cmd(cmd_t c);
		logic [15:0] q;
		logic [15:0] len;
		logic [15:0] w;
		logic [15:0] bc;
		step_res.delete();
		case (c.action)
			ACT_START: begin
				tid = tid + 16'd1;
				if (c.fcode == FC_READ_HOLD || c.fcode == FC_READ_INPUT)
					req_kind = RK_REG;
				else if (c.fcode == FC_READ_COILS || c.fcode == FC_READ_DISC)
					req_kind = RK_BIT;
				else
					req_kind = RK_WRITE;
				bits_left = (req_kind != RK_WRITE) ? {5'd0, c.quantity} : 16'd0;
				drop_frame();
				q = {5'd0, c.quantity};
				len = 16'd6;
				if (c.fcode == FC_WRITE_MULTI) begin
					if (q > MAX_WRITE_WORDS)
						q = 16'(MAX_WRITE_WORDS);
					len = 16'd7 + (q << 1);
					w = q;
				end else if (c.fcode == FC_WRITE_COIL) begin
					w = (c.word_value != 16'h0000) ? COIL_ON : COIL_OFF;
				end else if (c.fcode == FC_WRITE_REG) begin
					w = c.word_value;
				end else begin
					w = {5'd0, c.quantity};
				end
				emit_tx(tid[15:8]);
				emit_tx(tid[7:0]);
				emit_tx(8'h00);
				emit_tx(8'h00);
				emit_tx(len[15:8]);
				emit_tx(len[7:0]);
				emit_tx(unit_id);
				emit_tx(c.fcode);
				emit_tx(c.start_address[15:8]);
				emit_tx(c.start_address[7:0]);
				emit_tx(w[15:8]);
				emit_tx(w[7:0]);
				if (c.fcode == FC_WRITE_MULTI) begin
					bc = q << 1;
					emit_tx(bc[7:0]);
				end
			end
			ACT_WORD: begin
				emit_tx(c.word_value[15:8]);
				emit_tx(c.word_value[7:0]);
			end
			ACT_RX: parse_byte(c.rx_byte);
			default: ;
		endcase
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			due_res.insert(due_res.size(), step_res[i]);
	endfunction

	function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			bad_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_res(res_t got);
		res_t want;
		if (due_res.size() == 0) begin
			bad_count++;
			$display("%0t: unexpected result, expected none, got kind %0d tx %0h",
				$time, got.kind, got.tx_byte);
			$display("%0t:   data %0h st %0d exc %0h last %0b",
				$time, got.data_word, got.status, got.exception_code, got.last);
			return;
		end
		want = due_res.pop_front();
		cmp_field("kind", want.kind, got.kind);
		cmp_field("tx_byte", want.tx_byte, got.tx_byte);
		cmp_field("data_word", want.data_word, got.data_word);
		cmp_field("status", want.status, got.status);
		cmp_field("exception_code", want.exception_code, got.exception_code);
		cmp_field("last", want.last, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_id = 8'h00;
			tid = 16'd0;
			drop_frame();
			hi_byte = 8'h00;
			bits_left = 16'd0;
			req_kind = RK_WRITE;
			due_res.delete();
			n_due <= 0;
			n_bad <= bad_count;
		end else begin
			if (cfg_we)
				unit_id = cfg_wdata;
			if (cmd_valid && !cmd_stall)
				apply_cmd(cmd);
			if (res_valid && !res_stall)
				check_res(res);
			n_due <= due_res.size();
			n_bad <= bad_count;
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the modbus tcp master framer
// depends on mtf_pkg, modbus_tcp_master_framer and mtf_checker
module tb_top;
	import mtf_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int WRITE_CAP = 123;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS = 20;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_t       cmd = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_t       res;

	int   send_idle_pct = 13;
	int   recv_idle_pct = 53;
	logic hold_off = 1'b0;
	int   n_due;
	int   n_bad;
	int   n_items = 0;
	int   cycles = 0;

	modbus_tcp_master_framer #(
		.MAX_WRITE_WORDS(WRITE_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	mtf_checker #(
		.MAX_WRITE_WORDS(WRITE_CAP)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.n_due(n_due),
		.n_bad(n_bad)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
			res_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic cmd_t any_cmd();
		cmd_t c;
		c.action = ACT_NONE;
		c.fcode = 8'($urandom);
		c.start_address = 16'($urandom);
		c.quantity = 11'($urandom_range(0, 2000));
		c.word_value = 16'($urandom);
		c.rx_byte = 8'($urandom);
		return c;
	endfunction

	// entered and left at a falling edge; valid stays up between back-to-back requests
	task automatic push_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd = c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		if (c.action != ACT_NONE)
			n_items++;
		@(negedge clk);
	endtask

	task automatic send_start(logic [7:0] fc, logic [15:0] addr, logic [10:0] qty,
		logic [15:0] val);
		cmd_t c;
		c = any_cmd();
		c.action = ACT_START;
		c.fcode = fc;
		c.start_address = addr;
		c.quantity = qty;
		c.word_value = val;
		push_cmd(c);
	endtask

	task automatic send_word(logic [15:0] val);
		cmd_t c;
		c = any_cmd();
		c.action = ACT_WORD;
		c.word_value = val;
		push_cmd(c);
	endtask

	task automatic send_rx(logic [7:0] b);
		cmd_t c;
		c = any_cmd();
		c.action = ACT_RX;
		c.rx_byte = b;
		push_cmd(c);
	endtask

	task automatic send_action_none();
		cmd_t c;
		c = any_cmd();
		c.action = ACT_NONE;
		push_cmd(c);
	endtask

	// transaction and protocol id bytes are don't-care for the parser
	task automatic send_header(logic [15:0] len);
		repeat (4) send_rx(8'($urandom));
		send_rx(len[15:8]);
		send_rx(len[7:0]);
	endtask

	task automatic wait_quiet();
		cmd_valid = 1'b0;
		while (n_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_unit(logic [7:0] val);
		cfg_we = 1'b1;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_exchange();
		logic [7:0]  fc;
		logic [10:0] qty;
		logic [15:0] val;
		logic [7:0]  body[$];
		int          pick;
		int          shape;
		int          nbytes;
		int          len;
		int          reps;
		pick = $urandom_range(99);
		if (pick < 25)
			fc = $urandom_range(1) ? FC_READ_HOLD : FC_READ_INPUT;
		else if (pick < 45)
			fc = $urandom_range(1) ? FC_READ_COILS : FC_READ_DISC;
		else if (pick < 55)
			fc = FC_WRITE_COIL;
		else if (pick < 65)
			fc = FC_WRITE_REG;
		else if (pick < 80)
			fc = FC_WRITE_MULTI;
		else
			fc = 8'($urandom);
		if ($urandom_range(9) == 0)
			qty = 11'($urandom_range(0, 2000));
		else
			qty = 11'($urandom_range(0, 6));
		val = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
		send_start(fc, 16'($urandom), qty, val);
		if (fc == FC_WRITE_MULTI)
			repeat ($urandom_range(0, 3)) send_word(16'($urandom));
		if ($urandom_range(19) == 0)
			send_action_none();

		body.insert(body.size(), 8'($urandom));
		shape = $urandom_range(99);
		if (shape < 65) begin
			// well formed reply, sometimes with bytes past the byte count
			body.insert(body.size(), fc);
			if (fc == FC_READ_HOLD || fc == FC_READ_INPUT)
				nbytes = 2 * qty;
			else if (fc == FC_READ_COILS || fc == FC_READ_DISC)
				nbytes = (qty + 7) / 8;
			else
				nbytes = -1;
			if (nbytes > 24)
				nbytes = $urandom_range(0, 24);
			if (nbytes >= 0) begin
				body.insert(body.size(), 8'(nbytes));
				repeat (nbytes) body.insert(body.size(), 8'($urandom));
			end else begin
				repeat (4) body.insert(body.size(), 8'($urandom));
			end
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 3)) body.insert(body.size(), 8'($urandom));
		end else if (shape < 75) begin
			body.insert(body.size(), fc | 8'h80);
			if ($urandom_range(3) != 0)
				body.insert(body.size(), 8'($urandom));
		end else if (shape < 85) begin
			// ends before the byte count
			if ($urandom_range(1))
				body.insert(body.size(), fc);
		end else begin
			// arbitrary byte count against whatever data follows
			body.insert(body.size(), fc);
			body.insert(body.size(), 8'($urandom));
			repeat ($urandom_range(0, 8)) body.insert(body.size(), 8'($urandom));
		end

		reps = ($urandom_range(9) == 0) ? 2 : 1;
		repeat (reps) begin
			len = body.size();
			pick = $urandom_range(19);
			if (pick == 0)
				len = 0;
			else if (pick == 1)
				len = len + $urandom_range(1, 3);
			send_header(16'(len));
			if (len != 0)
				foreach (body[i])
					send_rx(body[i]);
		end
	endtask

	task automatic random_phase();
		int target;
		target = n_items + PHASE_ITEMS;
		while (n_items < target)
			random_exchange();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		write_unit(8'hFF);
		send_start(FC_WRITE_MULTI, 16'h0000, 11'd2000, 16'hFFFF);
		send_word(16'hFFFF);
		send_word(16'h0000);
		send_start(FC_WRITE_COIL, 16'hFFFF, 11'd0, 16'h0001);
		send_start(FC_READ_COILS, 16'h1234, 11'd3, 16'h0000);
		send_header(16'd4);
		send_rx(8'hFF);
		send_rx(FC_READ_COILS);
		send_rx(8'd1);
		send_rx(8'hFF);
		// zero length field
		send_header(16'd0);
		// exception bit set, frame ends before the code byte
		send_start(FC_READ_HOLD, 16'h00FF, 11'd2, 16'h0000);
		send_header(16'd2);
		send_rx(8'h00);
		send_rx(FC_READ_HOLD | 8'h80);
		wait_quiet();

		write_unit(8'h00);
		send_action_none();
		hold_off = 1'b1;
		random_phase();
		wait_quiet();

		send_idle_pct = 53;
		recv_idle_pct = 13;
		write_unit(8'($urandom));
		random_phase();
		wait_quiet();
		random_phase();
		wait_quiet();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_unit(8'hFF);
		hold_off = 1'b1;
		random_phase();

		wait_quiet();
		if (n_bad == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
